// File: hw/rtl/gf256_arithmetic_unit_assert.svh
// Assertion macros for the GF(2^8) arithmetic unit.
// Depends on nothing; included inside module bodies that assert.
`ifndef GF256_ARITHMETIC_UNIT_ASSERT_SVH
`define GF256_ARITHMETIC_UNIT_ASSERT_SVH

// same-cycle implication, reset-qualified
`define GFAU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset-qualified
`define GFAU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/gfau_pkg.sv
// Shared types, command codes and log/exp tables for the GF(2^8) unit.
// No dependencies.
package gfau_pkg;

	// command codes
	typedef enum logic [2:0] {
		CMD_ADD = 3'd0,
		CMD_NEG = 3'd1,
		CMD_MUL = 3'd2,
		CMD_DIV = 3'd3,
		CMD_INV = 3'd4
	} gfau_cmd_t;

	// field reduction constants (x^8+x^4+x^3+x+1)
	localparam logic [7:0] POLY_LOW = 8'h1b;
	localparam logic [7:0] TOP_BIT  = 8'h80;
	localparam logic [7:0] GROUP_ORDER = 8'd255;

	typedef struct packed {
		logic [2:0] command;
		logic [7:0] operand_a;
		logic [7:0] operand_b;
	} gfau_req_t;

	typedef struct packed {
		logic [7:0] result;
		logic       zero_divide;
	} gfau_rsp_t;

	typedef logic [255:0][7:0] gf_tbl_t;

	// multiply by x, reduced
	function automatic logic [7:0] xtime(input logic [7:0] v);
		logic [7:0] sh;
		sh = {v[6:0], 1'b0};
		return ((v & TOP_BIT) != 8'h00) ? (sh ^ POLY_LOW) : sh;
	endfunction

	// powers of generator 0x03; entry 255 wraps to 1
	function automatic gf_tbl_t build_exp();
		gf_tbl_t    t;
		logic [7:0] x;
		t = '0;
		x = 8'h01;
		for (int i = 0; i < 255; i++) begin
			t[i] = x;
			x = x ^ xtime(x);
		end
		t[255] = 8'h01;
		return t;
	endfunction

	// discrete log base 0x03; log of zero left as 0 (never used)
	function automatic gf_tbl_t build_log(input gf_tbl_t e);
		gf_tbl_t t;
		t = '0;
		for (int i = 0; i < 255; i++) begin
			t[e[i]] = 8'(i);
		end
		return t;
	endfunction

	localparam gf_tbl_t EXP_TBL = build_exp();
	localparam gf_tbl_t LOG_TBL = build_log(EXP_TBL);

endpackage

// File: hw/rtl/gfau_field_ops.sv
// Combinational field operations: add, identity, log/exp multiply, divide, inverse.
// Depends on gfau_pkg.
module gfau_field_ops (
	input  gfau_pkg::gfau_req_t req,
	output gfau_pkg::gfau_rsp_t rsp
);
	import gfau_pkg::*;

	logic [7:0] a, b;
	logic [7:0] log_a, log_b;
	logic [7:0] neg_log_a, neg_log_b;
	logic [7:0] exp_p, exp_q;
	logic [8:0] exp_sum;
	logic [7:0] exp_red;
	logic [7:0] pow_val;

	assign a = req.operand_a;
	assign b = req.operand_b;

	// log lookups and their negations mod 255
	assign log_a = LOG_TBL[a];
	assign log_b = LOG_TBL[b];
	assign neg_log_a = (log_a == 8'd0) ? 8'd0 : GROUP_ORDER - log_a;
	assign neg_log_b = (log_b == 8'd0) ? 8'd0 : GROUP_ORDER - log_b;

	// exponent operands: mul la+lb, div la-lb, inv -la
	always_comb begin
		exp_p = log_a;
		exp_q = log_b;
		case (gfau_cmd_t'(req.command))
			CMD_DIV: exp_q = neg_log_b;
			CMD_INV: begin
				exp_p = 8'd0;
				exp_q = neg_log_a;
			end
			default: ;
		endcase
	end

	// one compare-and-subtract brings the sum below 255
	assign exp_sum = {1'b0, exp_p} + {1'b0, exp_q};
	assign exp_red = (exp_sum >= {1'b0, GROUP_ORDER}) ?
		8'(exp_sum - {1'b0, GROUP_ORDER}) : exp_sum[7:0];
	assign pow_val = EXP_TBL[exp_red];

	// result selection and zero handling
	always_comb begin
		rsp = '0;
		case (gfau_cmd_t'(req.command))
			CMD_ADD: rsp.result = a ^ b;
			CMD_NEG: rsp.result = a;
			CMD_MUL: rsp.result = (a == 8'd0 || b == 8'd0) ? 8'd0 : pow_val;
			CMD_DIV: begin
				rsp.zero_divide = (b == 8'd0);
				rsp.result = (a == 8'd0 || b == 8'd0) ? 8'd0 : pow_val;
			end
			CMD_INV: begin
				rsp.zero_divide = (a == 8'd0);
				rsp.result = (a == 8'd0) ? 8'd0 : pow_val;
			end
			default: ;
		endcase
	end

endmodule

// File: hw/rtl/gf256_arithmetic_unit.sv
// Top level of the GF(2^8) arithmetic unit: request register, field logic, response register.
// Depends on gfau_pkg, gfau_field_ops and gf256_arithmetic_unit_assert.svh.
//
// Takes one request per clock cycle: busy is always low, so a request is taken at every
// edge where start is high. The request register loads at the request edge and the response
// register at the next one, so the response appears with done high for one cycle starting one
// clock edge after the request edge, and must be captured at the edge that ends that cycle:
// there is no back-pressure on the response side. Responses come out in request order.
// Division by zero and inversion of zero give result 0 with zero_divide set; unknown command
// codes give result 0 without the flag. Multiply, divide and inverse go through 256-entry log
// and exp tables of generator 0x03, built as constant logic.
module gf256_arithmetic_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  gfau_pkg::gfau_req_t request,
	output logic                busy,
	output logic                done,
	output gfau_pkg::gfau_rsp_t response
);
	import gfau_pkg::*;

	`include "gf256_arithmetic_unit_assert.svh"

	logic      valid_s1;
	gfau_req_t req_s1;
	gfau_rsp_t rsp_comb;
	logic      done_s2;
	gfau_rsp_t rsp_s2;

	// no internal hazard: always ready
	assign busy = 1'b0;

	// request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start & ~busy) begin
			req_s1 <= request;
		end
	end

	gfau_field_ops u_ops (
		.req (req_s1),
		.rsp (rsp_comb)
	);

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			rsp_s2 <= rsp_comb;
		end
	end

	assign done     = done_s2;
	assign response = rsp_s2;

	// checks
	`GFAU_ASSERT_NXT(ap_done_follows, clk, arst_n, valid_s1, done, "done missing after stage 1")
	`GFAU_ASSERT_NXT(ap_no_spurious, clk, arst_n, !valid_s1, !done, "done without request")
	`GFAU_ASSERT_IMP(ap_err_zero, clk, arst_n, done && response.zero_divide,
		response.result == 8'd0, "zero_divide with nonzero result")
	`GFAU_ASSERT_IMP(ap_err_cmd, clk, arst_n, valid_s1 && rsp_comb.zero_divide,
		req_s1.command == CMD_DIV || req_s1.command == CMD_INV,
		"zero_divide on a command that cannot divide")

endmodule
